// ===== hw/rtl/mtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_pkg: shared types and constants for the message tag matcher
// Table geometry, status codes, table entry layout and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mtm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // result status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_MATCHED = 3'd1;
    localparam logic [2:0] ST_SIZE    = 3'd2;
    localparam logic [2:0] ST_CLASH   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // item kinds
    localparam logic KIND_SEND    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] rank;
        logic [30:0] seq;
        logic [47:0] addr;
        logic [31:0] bytes;
        logic [31:0] notify;
        logic [31:0] counter;
        logic [31:0] age;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;   // accepting an item
        logic scan_rd;    // read table at scan index, advance
        logic hit_rd;     // read table at best match index
        logic commit;     // update table, load result register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;  // scan index is at the last entry
        logic out_busy;   // result register holds an untaken result
    } dp_stat_t;

endpackage

// ===== hw/rtl/mtm_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_item_if: input channel of the message tag matcher
// Valid/ready channel carrying one send or receive request.
// ----------------------------------------------------------------------------
interface mtm_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] peer_rank;
    logic [47:0] buffer_addr;
    logic [31:0] byte_count;
    logic [30:0] seq_num;
    logic [31:0] notify_handle;
    logic [31:0] counter_handle;

    modport source (output valid, command, peer_rank, buffer_addr, byte_count,
                    seq_num, notify_handle, counter_handle, input ready);
    modport sink   (input valid, command, peer_rank, buffer_addr, byte_count,
                    seq_num, notify_handle, counter_handle, output ready);
endinterface

// ===== hw/rtl/mtm_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_result_if: result channel of the message tag matcher
// Valid/ready channel carrying status and copy descriptor.
// ----------------------------------------------------------------------------
interface mtm_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [47:0] copy_src_addr;
    logic [47:0] copy_dst_addr;
    logic [31:0] copy_bytes;
    logic [31:0] signal_out;
    logic [31:0] done_out;
    logic [31:0] counter_out;

    modport source (output valid, status, copy_src_addr, copy_dst_addr, copy_bytes,
                    signal_out, done_out, counter_out, input ready);
    modport sink   (input valid, status, copy_src_addr, copy_dst_addr, copy_bytes,
                    signal_out, done_out, counter_out, output ready);
endinterface

// ===== hw/rtl/mtm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_ctrl: sequencer of the message tag matcher
// Accept, scan every table entry, fetch the best match, commit the result.
// ----------------------------------------------------------------------------
module mtm_ctrl
    import mtm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FETCH,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (item_valid) state_next = S_SCAN;
            S_SCAN:  if (stat.scan_last) state_next = S_TAIL;
            S_TAIL:  state_next = S_FETCH;
            S_FETCH: state_next = S_FIN;
            S_FIN:   if (!stat.out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.in_ready = (state_reg == S_IDLE);
        cmd.scan_rd  = (state_reg == S_SCAN);
        cmd.hit_rd   = (state_reg == S_FETCH);
        cmd.commit   = (state_reg == S_FIN) && !stat.out_busy;
    end

    // a commit only ever follows a fetch or a stalled commit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> ($past(state_reg) == S_FETCH || $past(state_reg) == S_FIN))
        else $error("commit without fetch");
    // the scan ends exactly at the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && stat.scan_last) |=> state_reg == S_TAIL)
        else $error("scan overrun");
    // no item is taken while work is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.in_ready |-> !cmd.scan_rd && !cmd.hit_rd && !cmd.commit)
        else $error("accept during work");

endmodule

// ===== hw/rtl/mtm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_datapath: table, scan compare and result register
// Entry table in a one-port memory, valid bits in flops, running best match
// and free slot search, and the registered result.
// ----------------------------------------------------------------------------
module mtm_datapath
    import mtm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  ctl_cmd_t        cmd,
    output dp_stat_t        stat,
    mtm_item_if.sink        item,
    mtm_result_if.source    result
);

    entry_t              mem [TABLE_ENTRIES];
    entry_t              rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    entry_t              item_reg;
    logic [31:0]         age_stamp_reg;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    eval_idx_reg;
    logic                eval_reg;
    logic                hit_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [31:0]         best_age_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [47:0]         src_reg, dst_reg;
    logic [31:0]         bytes_reg, signal_reg, done_reg, counter_reg;

    logic                accept;
    logic                key_eq;
    logic [31:0]         cur_age;
    logic [2:0]          status_next;
    logic                do_store, do_match;

    assign accept         = item.valid && cmd.in_ready;
    assign item.ready     = cmd.in_ready;
    assign stat.scan_last = (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign stat.out_busy  = out_valid_reg && !result.ready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind    <= item.command;
            item_reg.rank    <= item.peer_rank;
            item_reg.seq     <= item.seq_num;
            item_reg.addr    <= item.buffer_addr;
            item_reg.bytes   <= item.byte_count;
            item_reg.notify  <= item.notify_handle;
            item_reg.counter <= item.counter_handle;
            item_reg.age     <= age_stamp_reg;
        end
    end

    // table memory: one read or write per cycle, registered read
    assign rd_addr = cmd.hit_rd ? hit_idx_reg : scan_idx_reg;

    always_ff @(posedge clk)
    begin
        if (do_store)
            mem[free_idx_reg] <= item_reg;
        // read data holds the fetched entry through a stalled commit
        if (cmd.scan_rd || cmd.hit_rd)
            rd_data_reg <= mem[rd_addr];
    end

    // scan compare on the entry read last cycle
    assign key_eq  = valid_reg[eval_idx_reg] && rd_data_reg.rank == item_reg.rank
                     && rd_data_reg.seq == item_reg.seq;
    assign cur_age = age_stamp_reg - rd_data_reg.age;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            eval_idx_reg   <= '0;
            eval_reg       <= 1'b0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            best_age_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            eval_reg     <= cmd.scan_rd;
            eval_idx_reg <= scan_idx_reg;
            if (accept)
            begin
                scan_idx_reg   <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (eval_reg)
                begin
                    if (key_eq && (!hit_found_reg || cur_age > best_age_reg))
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= eval_idx_reg;
                        best_age_reg  <= cur_age;
                    end
                    if (!valid_reg[eval_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= eval_idx_reg;
                    end
                end
            end
        end
    end

    // outcome; rd_data_reg holds the best match entry at commit
    always_comb
    begin
        if (hit_found_reg)
        begin
            if (rd_data_reg.bytes != item_reg.bytes)
                status_next = ST_SIZE;
            else if (rd_data_reg.kind == item_reg.kind)
                status_next = ST_CLASH;
            else
                status_next = ST_MATCHED;
        end
        else if (free_found_reg)
            status_next = ST_STORED;
        else
            status_next = ST_FULL;
    end

    assign do_store = cmd.commit && status_next == ST_STORED;
    assign do_match = cmd.commit && status_next == ST_MATCHED;

    // valid bits and age stamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            age_stamp_reg <= '0;
        end
        else
        begin
            if (do_store)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                age_stamp_reg           <= age_stamp_reg + 32'd1;
            end
            if (do_match)
                valid_reg[hit_idx_reg] <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            src_reg     <= '0;
            dst_reg     <= '0;
            bytes_reg   <= '0;
            signal_reg  <= '0;
            done_reg    <= '0;
            counter_reg <= '0;
            if (status_next == ST_MATCHED)
            begin
                bytes_reg <= item_reg.bytes;
                if (item_reg.kind == KIND_SEND)
                begin
                    src_reg     <= item_reg.addr;
                    dst_reg     <= rd_data_reg.addr;
                    signal_reg  <= rd_data_reg.notify;
                    done_reg    <= item_reg.notify;
                    counter_reg <= item_reg.counter;
                end
                else
                begin
                    src_reg     <= rd_data_reg.addr;
                    dst_reg     <= item_reg.addr;
                    signal_reg  <= item_reg.notify;
                    done_reg    <= rd_data_reg.notify;
                    counter_reg <= rd_data_reg.counter;
                end
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = status_reg;
    assign result.copy_src_addr = src_reg;
    assign result.copy_dst_addr = dst_reg;
    assign result.copy_bytes    = bytes_reg;
    assign result.signal_out    = signal_reg;
    assign result.done_out      = done_reg;
    assign result.counter_out   = counter_reg;

    // a stored item occupies a slot that was free
    assert property (@(posedge clk) disable iff (!rst_n)
        do_store |-> !valid_reg[free_idx_reg])
        else $error("store over live entry");
    // a match frees a live entry
    assert property (@(posedge clk) disable iff (!rst_n)
        do_match |-> valid_reg[hit_idx_reg])
        else $error("match on dead entry");
    // the age stamp moves only on a store
    assert property (@(posedge clk) disable iff (!rst_n)
        !do_store |=> $stable(age_stamp_reg))
        else $error("age stamp moved");

endmodule

// ===== hw/rtl/message_tag_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_tag_matcher_core: sender-side message tag matcher
// Matches local sends against remote receive requests by rank and sequence.
// ----------------------------------------------------------------------------
// One item is handled at a time: the entry table sits in a single-port
// memory that is read one entry per cycle to find the oldest match and the
// lowest free slot, a tail step evaluates the last entry, a fetch step
// reads the matching entry and a final step commits. A result waits in an
// output register; the next item is taken once that result has been loaded,
// and a commit stalls while an earlier result is still untaken. No clearing
// pass is needed after reset.
module message_tag_matcher_core
    import mtm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mtm_item_if.sink     item,
    mtm_result_if.source result
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    mtm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .stat       (stat),
        .cmd        (cmd)
    );

    mtm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule
